/* rtl/rgb332_pan_crop_stream_defines.svh */
// Assertion macros shared by the RTL of the RGB332 pan and crop stream block.
// No dependencies; the assertion forms are left empty when SYNTHESIS is defined.
`ifndef RGB332_PAN_CROP_STREAM_DEFINES_SVH
`define RGB332_PAN_CROP_STREAM_DEFINES_SVH
`ifndef SYNTHESIS
`define RPC_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("rpc assertion failed");
`define RPC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rpc assertion failed");
`else
`define RPC_ASSERT_SAME(lbl, clk, rst_n, ante, cons)
`define RPC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

/* rtl/rpc_pkg.sv */
// Package of the RGB332 pan and crop stream: widths, register indexes and
// the configuration and window geometry structs. No dependencies.
package rpc_pkg;

    localparam int MAX_DIM_BITS = 12;
    localparam int CFG_DIM_W    = 13;
    localparam int CFG_PAN_W    = 12;
    localparam int COLOR_W      = 8;
    localparam int PIX_W        = 8;
    localparam int ADDR_W       = 24;
    localparam int APB_DATA_W   = 32;
    localparam int APB_ADDR_W   = 5;
    localparam int IDX_W        = APB_ADDR_W - 2;

    localparam int DIM_W = (MAX_DIM_BITS + 1 > CFG_DIM_W) ? MAX_DIM_BITS + 1 : CFG_DIM_W;
    localparam int SUM_W = DIM_W + 1;

    localparam logic [DIM_W-1:0] DIM_LIMIT = DIM_W'(1) << MAX_DIM_BITS;

    localparam logic [CFG_DIM_W-1:0] RST_IMAGE_WIDTH   = CFG_DIM_W'(640);
    localparam logic [CFG_DIM_W-1:0] RST_IMAGE_HEIGHT  = CFG_DIM_W'(480);
    localparam logic [CFG_DIM_W-1:0] RST_SCREEN_WIDTH  = CFG_DIM_W'(640);
    localparam logic [CFG_DIM_W-1:0] RST_SCREEN_HEIGHT = CFG_DIM_W'(480);

    typedef enum logic [IDX_W-1:0] {
        REG_IMAGE_WIDTH   = 3'd0,
        REG_IMAGE_HEIGHT  = 3'd1,
        REG_SCREEN_WIDTH  = 3'd2,
        REG_SCREEN_HEIGHT = 3'd3,
        REG_PAN_X         = 3'd4,
        REG_PAN_Y         = 3'd5
    } t_reg_idx;

    typedef struct packed {
        logic [CFG_DIM_W-1:0] image_width;
        logic [CFG_DIM_W-1:0] image_height;
        logic [CFG_DIM_W-1:0] screen_width;
        logic [CFG_DIM_W-1:0] screen_height;
        logic [CFG_PAN_W-1:0] pan_x;
        logic [CFG_PAN_W-1:0] pan_y;
    } t_cfg;

    typedef struct packed {
        logic [DIM_W-1:0]     iw;
        logic [DIM_W-1:0]     ih;
        logic [CFG_PAN_W-1:0] px;
        logic [CFG_PAN_W-1:0] py;
        logic [SUM_W-1:0]     x_end;
        logic [SUM_W-1:0]     y_end;
        logic [CFG_DIM_W-1:0] stride;
    } t_geom;

endpackage

/* rtl/rpc_if.sv */
// Stream interfaces of the RGB332 pan and crop block: RGB888 pixel words in,
// packed pixel and framebuffer address words out. Depends on rpc_pkg.
interface rpc_pix_if import rpc_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [COLOR_W-1:0] red_in;
    logic [COLOR_W-1:0] green_in;
    logic [COLOR_W-1:0] blue_in;

    modport source (output valid, output red_in, output green_in, output blue_in,
                    input ready);
    modport sink (input valid, input red_in, input green_in, input blue_in,
                  output ready);
endinterface

interface rpc_res_if import rpc_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [PIX_W-1:0]  packed_pixel;
    logic [ADDR_W-1:0] fb_address;

    modport source (output valid, output packed_pixel, output fb_address, input ready);
    modport sink (input valid, input packed_pixel, input fb_address, output ready);
endinterface

/* rtl/rpc_apb_regs.sv */
// APB register bank of the RGB332 pan and crop block: image size, screen
// size and pan offset. Depends on rpc_pkg.
module rpc_apb_regs import rpc_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready,
    output t_cfg                  o_cfg
);

    t_cfg     r_cfg;
    t_reg_idx idx;
    logic     wr_en;

    assign idx    = t_reg_idx'(paddr[APB_ADDR_W-1:2]);
    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;
    assign o_cfg  = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.image_width   <= RST_IMAGE_WIDTH;
            r_cfg.image_height  <= RST_IMAGE_HEIGHT;
            r_cfg.screen_width  <= RST_SCREEN_WIDTH;
            r_cfg.screen_height <= RST_SCREEN_HEIGHT;
            r_cfg.pan_x         <= '0;
            r_cfg.pan_y         <= '0;
        end else if (wr_en) begin
            case (idx)
                REG_IMAGE_WIDTH:   r_cfg.image_width   <= pwdata[CFG_DIM_W-1:0];
                REG_IMAGE_HEIGHT:  r_cfg.image_height  <= pwdata[CFG_DIM_W-1:0];
                REG_SCREEN_WIDTH:  r_cfg.screen_width  <= pwdata[CFG_DIM_W-1:0];
                REG_SCREEN_HEIGHT: r_cfg.screen_height <= pwdata[CFG_DIM_W-1:0];
                REG_PAN_X:         r_cfg.pan_x         <= pwdata[CFG_PAN_W-1:0];
                REG_PAN_Y:         r_cfg.pan_y         <= pwdata[CFG_PAN_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (idx)
            REG_IMAGE_WIDTH:   prdata = APB_DATA_W'(r_cfg.image_width);
            REG_IMAGE_HEIGHT:  prdata = APB_DATA_W'(r_cfg.image_height);
            REG_SCREEN_WIDTH:  prdata = APB_DATA_W'(r_cfg.screen_width);
            REG_SCREEN_HEIGHT: prdata = APB_DATA_W'(r_cfg.screen_height);
            REG_PAN_X:         prdata = APB_DATA_W'(r_cfg.pan_x);
            REG_PAN_Y:         prdata = APB_DATA_W'(r_cfg.pan_y);
            default:           prdata = '0;
        endcase
    end

endmodule

/* rtl/rpc_geom.sv */
// Window geometry of the RGB332 pan and crop block: saturated image size,
// corrected pan offset and window ends. Depends on rpc_pkg.
module rpc_geom import rpc_pkg::*; (
    input  t_cfg  i_cfg,
    output t_geom o_geom
);

    logic [DIM_W-1:0] iw, ih, sw, sh, xc, yc;
    logic [SUM_W-1:0] pan_x_reach, pan_y_reach;
    logic [CFG_PAN_W-1:0] px, py;

    always_comb begin
        iw = (DIM_W'(i_cfg.image_width) > DIM_LIMIT) ? DIM_LIMIT : DIM_W'(i_cfg.image_width);
        ih = (DIM_W'(i_cfg.image_height) > DIM_LIMIT) ? DIM_LIMIT
                                                       : DIM_W'(i_cfg.image_height);
        sw = DIM_W'(i_cfg.screen_width);
        sh = DIM_W'(i_cfg.screen_height);
        xc = (iw < sw) ? iw : sw;
        yc = (ih < sh) ? ih : sh;
        // pan > image - screen, rearranged to stay unsigned
        pan_x_reach = SUM_W'(i_cfg.pan_x) + SUM_W'(sw);
        pan_y_reach = SUM_W'(i_cfg.pan_y) + SUM_W'(sh);
        px = (pan_x_reach > SUM_W'(iw)) ? '0 : i_cfg.pan_x;
        py = (pan_y_reach > SUM_W'(ih)) ? '0 : i_cfg.pan_y;

        o_geom.iw     = iw;
        o_geom.ih     = ih;
        o_geom.px     = px;
        o_geom.py     = py;
        o_geom.x_end  = SUM_W'(px) + SUM_W'(xc);
        o_geom.y_end  = SUM_W'(py) + SUM_W'(yc);
        o_geom.stride = i_cfg.screen_width;
    end

endmodule

/* rtl/rgb332_pan_crop_stream.sv */
// RGB888 to RGB332 packer with a panned crop window and framebuffer address.
// A pixel in the window gives a result word in the cycle after acceptance.
// Throughput: 1 pixel word per cycle unless the output register is stalled.
// Reset (synchronous, active low) clears the raster counters, the row base
// address and the output valid, and loads the default geometry 640x480.
`include "rgb332_pan_crop_stream_defines.svh"
module rgb332_pan_crop_stream import rpc_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    rpc_pix_if.sink               i_pix,
    rpc_res_if.source             o_res,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);

    t_cfg  cfg;
    t_geom geom;

    logic [MAX_DIM_BITS-1:0] r_col_count, n_col_count;
    logic [MAX_DIM_BITS-1:0] r_row_count, n_row_count;
    logic [ADDR_W-1:0]       r_row_base, n_row_base;
    logic                    r_out_valid, n_out_valid;
    logic [PIX_W-1:0]        r_pixel, n_pixel;
    logic [ADDR_W-1:0]       r_addr, n_addr;

    logic             pix_acc;
    logic             row_in, col_in, hit;
    logic             col_last, row_last;
    logic [SUM_W-1:0] col_ext, row_ext, col_off;

    rpc_apb_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    rpc_geom u_geom (
        .i_cfg  (cfg),
        .o_geom (geom)
    );

    assign i_pix.ready        = !r_out_valid || o_res.ready;
    assign pix_acc            = i_pix.valid && i_pix.ready;
    assign o_res.valid        = r_out_valid;
    assign o_res.packed_pixel = r_pixel;
    assign o_res.fb_address   = r_addr;

    always_comb begin
        col_ext  = SUM_W'(r_col_count);
        row_ext  = SUM_W'(r_row_count);
        row_in   = (row_ext >= SUM_W'(geom.py)) && (row_ext < geom.y_end);
        col_in   = (col_ext >= SUM_W'(geom.px)) && (col_ext < geom.x_end);
        hit      = row_in && col_in;
        col_last = (col_ext + SUM_W'(1)) >= SUM_W'(geom.iw);
        row_last = (row_ext + SUM_W'(1)) >= SUM_W'(geom.ih);
        col_off  = col_ext - SUM_W'(geom.px);

        n_pixel = {i_pix.red_in[7:5], i_pix.green_in[7:5], i_pix.blue_in[7:6]};
        n_addr  = r_row_base + ADDR_W'(col_off[MAX_DIM_BITS-1:0]);

        n_col_count = r_col_count;
        n_row_count = r_row_count;
        n_row_base  = r_row_base;
        n_out_valid = r_out_valid && !o_res.ready;
        if (pix_acc) begin
            n_out_valid = hit;
            if (col_last) begin
                n_col_count = '0;
                if (row_last) begin
                    n_row_count = '0;
                    n_row_base  = '0;
                end else begin
                    n_row_count = r_row_count + MAX_DIM_BITS'(1);
                    if (row_in) begin
                        n_row_base = r_row_base + ADDR_W'(geom.stride);
                    end
                end
            end else begin
                n_col_count = r_col_count + MAX_DIM_BITS'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col_count <= '0;
            r_row_count <= '0;
            r_row_base  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_col_count <= n_col_count;
            r_row_count <= n_row_count;
            r_row_base  <= n_row_base;
            r_out_valid <= n_out_valid;
        end
    end

    // load the result word on every accepted pixel
    always_ff @(posedge i_clk) begin
        if (pix_acc) begin
            r_pixel <= n_pixel;
            r_addr  <= n_addr;
        end
    end

    `RPC_ASSERT_SAME(a_stall_blocks_input, i_clk, i_rst_n,
                     r_out_valid && !o_res.ready, !i_pix.ready)
    `RPC_ASSERT_NEXT(a_hit_gives_word, i_clk, i_rst_n, pix_acc && hit, r_out_valid)
    `RPC_ASSERT_NEXT(a_frame_end_clears, i_clk, i_rst_n,
                     pix_acc && col_last && row_last,
                     (r_col_count == '0) && (r_row_count == '0) && (r_row_base == '0))

endmodule
